FILE: hdl/hds_pkg.sv
// Shared constants, types and record layouts for the heat diffusion stencil step unit.
package hds_pkg;

	// Grid geometry
	localparam int GRID_WIDTH  = 128;
	localparam int GRID_HEIGHT = 128;
	localparam int COL_W       = $clog2(GRID_WIDTH);
	localparam int ROW_W       = $clog2(GRID_HEIGHT);

	// Field widths
	localparam int TEMP_W    = 32;
	localparam int COEF_W    = 16;
	localparam int IDX_W     = 7;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Arithmetic widths: Laplacian term, product, Q.32 sum, Q16.16 before clamp
	localparam int LAP_W = TEMP_W + 3;
	localparam int MUL_W = LAP_W + COEF_W + 1;
	localparam int ACC_W = MUL_W + 1;
	localparam int Q_W   = ACC_W - FRAC_W;

	// Line buffer word holds {row above, row middle}
	localparam int RAM_W = 2 * TEMP_W;

	// Result queue and admission credit
	localparam int OQ_DEPTH    = 16;
	localparam int OQ_AW       = $clog2(OQ_DEPTH);
	localparam int OQ_CW       = OQ_AW + 1;
	localparam int PIPE_STAGES = 4;
	localparam int CRED_W      = $clog2(OQ_DEPTH + 2 * (PIPE_STAGES + 1) + 1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = CFG_IDX_W'(1);

	localparam logic [COEF_W-1:0] COEF_RST = COEF_W'(16384);

	localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

	// Position and emit decisions of one accepted cell
	typedef struct packed {
		logic             emit_mid;
		logic             emit_pass;
		logic             border;
		logic             frame_end;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} tag_t;

	// One result record
	typedef struct packed {
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [TEMP_W-1:0] temp;
		logic                     sat;
		logic                     last;
		logic                     frame_done;
	} res_t;

	// Up to two results written to the queue in one cycle, r0 first
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

endpackage

FILE: hdl/hds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/hds_calc.sv
// Stencil arithmetic pipeline: Laplacians, coefficient products, rounding, clamp, result build.
module hds_calc
	import hds_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [COEF_W-1:0]            coef_x,
	input  logic [COEF_W-1:0]            coef_y,
	input  logic                         vld_s1,
	input  tag_t                         tag_s1,
	input  logic signed [TEMP_W-1:0]     left,
	input  logic signed [TEMP_W-1:0]     center,
	input  logic signed [TEMP_W-1:0]     right,
	input  logic signed [TEMP_W-1:0]     above,
	input  logic signed [TEMP_W-1:0]     below,
	output logic [PIPE_STAGES-2:0]       stage_vld,
	output push_t                        push
);

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

	logic                     vld_s2, vld_s3, vld_s4;
	tag_t                     tag_s2, tag_s3, tag_s4;
	logic signed [LAP_W-1:0]  lapx_s2, lapy_s2;
	logic signed [MUL_W-1:0]  prodx_s3, prody_s3;
	logic signed [ACC_W-1:0]  acc_s4;
	logic signed [TEMP_W-1:0] center_s2, center_s3, center_s4;
	logic signed [TEMP_W-1:0] pass_s2, pass_s3, pass_s4;
	logic signed [Q_W-1:0]    q_s4;
	logic                     ovf_hi, ovf_lo;
	logic signed [TEMP_W-1:0] upd_s4;
	res_t                     mid_res, pass_res;

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stage 2: second differences in both directions
	always_ff @(posedge clk) begin
		lapx_s2   <= LAP_W'(left) + LAP_W'(right) - (LAP_W'(center) <<< 1);
		lapy_s2   <= LAP_W'(above) + LAP_W'(below) - (LAP_W'(center) <<< 1);
		center_s2 <= center;
		pass_s2   <= below;
		tag_s2    <= tag_s1;
	end

	// Stage 3: scale by the diffusion coefficients
	always_ff @(posedge clk) begin
		prodx_s3  <= MUL_W'(lapx_s2) * MUL_W'($signed({1'b0, coef_x}));
		prody_s3  <= MUL_W'(lapy_s2) * MUL_W'($signed({1'b0, coef_y}));
		center_s3 <= center_s2;
		pass_s3   <= pass_s2;
		tag_s3    <= tag_s2;
	end

	// Stage 4: exact Q.32 sum plus half an LSB for round to nearest
	always_ff @(posedge clk) begin
		acc_s4    <= (ACC_W'(center_s3) <<< FRAC_W) + ACC_W'(prodx_s3)
			+ ACC_W'(prody_s3) + RND_HALF;
		center_s4 <= center_s3;
		pass_s4   <= pass_s3;
		tag_s4    <= tag_s3;
	end

	// Floor to Q16.16 and clamp to the 32-bit range
	assign q_s4   = acc_s4[ACC_W-1:FRAC_W];
	assign ovf_hi = !q_s4[Q_W-1] && (|q_s4[Q_W-2:TEMP_W-1]);
	assign ovf_lo = q_s4[Q_W-1] && !(&q_s4[Q_W-2:TEMP_W-1]);

	always_comb begin
		if (ovf_hi) begin
			upd_s4 = TEMP_MAX;
		end else if (ovf_lo) begin
			upd_s4 = TEMP_MIN;
		end else begin
			upd_s4 = q_s4[TEMP_W-1:0];
		end
	end

	// Build the updated cell of the row above and the pass-through cell of the last row
	always_comb begin
		mid_res.row        = IDX_W'(tag_s4.row - 1'b1);
		mid_res.col        = IDX_W'(tag_s4.col);
		mid_res.temp       = tag_s4.border ? center_s4 : upd_s4;
		mid_res.sat        = !tag_s4.border && (ovf_hi || ovf_lo);
		mid_res.last       = !tag_s4.emit_pass;
		// the row above the current one is never the final grid row
		mid_res.frame_done = 1'b0;

		pass_res.row        = IDX_W'(tag_s4.row);
		pass_res.col        = IDX_W'(tag_s4.col);
		pass_res.temp       = pass_s4;
		pass_res.sat        = 1'b0;
		pass_res.last       = 1'b1;
		pass_res.frame_done = tag_s4.frame_end;
	end

	// Order results: updated cell first, pass-through second
	always_comb begin
		push.v0 = vld_s4 && (tag_s4.emit_mid || tag_s4.emit_pass);
		push.v1 = vld_s4 && tag_s4.emit_mid && tag_s4.emit_pass;
		push.r0 = tag_s4.emit_mid ? mid_res : pass_res;
		push.r1 = pass_res;
	end

	assign stage_vld = {vld_s4, vld_s3, vld_s2};

endmodule

FILE: hdl/hds_outq.sv
// Result queue: takes up to two records per cycle, hands out one per transfer.
module hds_outq
	import hds_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  push_t            push,
	input  logic             pop,
	output res_t             head,
	output logic [OQ_CW-1:0] count
);

	res_t             mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_CW-1:0] count_q;
	logic [OQ_AW-1:0] wr_ptr_nx;

	assign wr_ptr_nx = wr_ptr_q + 1'b1;

	// Store incoming records
	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_ptr_nx] <= push.r1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_AW'(push.v0) + OQ_AW'(push.v1);
			rd_ptr_q <= rd_ptr_q + OQ_AW'(pop);
			count_q  <= count_q + OQ_CW'(push.v0) + OQ_CW'(push.v1) - OQ_CW'(pop);
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule

FILE: hdl/heat_diffusion_stencil_step_unit.sv
// Top level of the heat diffusion stencil step unit: counters, line buffer, window, admission.
//
//   channel   handshake               payload
//   cell      cell_valid / cell_stall  cell_temp
//   res       res_valid / res_stall    out_row, out_col, out_temp, sat_flag,
//                                      last_of_run, frame_done
//   cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One cell is taken per cycle while cell_stall is low; the first result of a cell passes
// through stages 1 to 4 and is registered into the result queue before it is offered.
// Rows 1 to GRID_HEIGHT-2 give one result per cell, the last row two, so there the output
// port (one transfer per cycle) limits the cell rate.
// cell_stall rises when the result queue could not absorb the pipeline and the next cell.
// Reset clears counters and queue, presets coefficients; the line buffer holds no reset state.
module heat_diffusion_stencil_step_unit
	import hds_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cell_valid,
	output logic                     cell_stall,
	input  logic signed [TEMP_W-1:0] cell_temp,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic signed [TEMP_W-1:0] out_temp,
	output logic                     sat_flag,
	output logic                     last_of_run,
	output logic                     frame_done,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [COEF_W-1:0]        cfg_data
);

	logic [COEF_W-1:0]        coef_x_q, coef_y_q;
	logic [ROW_W-1:0]         row_q, row_nx;
	logic [COL_W-1:0]         col_q, col_nx;
	logic                     col_wrap;
	logic                     accept;
	tag_t                     tag_s0;

	logic                     vld_s1;
	tag_t                     tag_s1;
	logic signed [TEMP_W-1:0] cur_s1;

	logic [RAM_W-1:0]         rd_data;
	logic [RAM_W-1:0]         wr_data;
	logic signed [TEMP_W-1:0] rd_mid, rd_above;
	logic signed [TEMP_W-1:0] nxt_mid_q, nxt_above_q, left_q;

	logic [PIPE_STAGES-2:0]   stage_vld;
	push_t                    push;
	res_t                     head;
	logic [OQ_CW-1:0]         oq_count;
	logic [CRED_W-1:0]        need;
	logic                     pop;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q <= COEF_RST;
			coef_y_q <= COEF_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COEF_X: coef_x_q <= cfg_data;
				REG_COEF_Y: coef_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Admission: worst case two results for every cell in flight and the next one
	assign need = CRED_W'(oq_count)
		+ (CRED_W'($countones({vld_s1, stage_vld})) << 1) + CRED_W'(2);
	assign cell_stall = need > CRED_W'(OQ_DEPTH);
	assign accept     = cell_valid && !cell_stall;

	// Raster position of the next cell
	assign col_wrap = col_q == COL_W'(GRID_WIDTH - 1);
	assign col_nx   = col_wrap ? '0 : col_q + 1'b1;
	assign row_nx   = (row_q == ROW_W'(GRID_HEIGHT - 1)) ? '0 : row_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			col_q <= col_nx;
			if (col_wrap) begin
				row_q <= row_nx;
			end
		end
	end

	// Classify the cell on transfer
	always_comb begin
		tag_s0.row       = row_q;
		tag_s0.col       = col_q;
		tag_s0.emit_mid  = row_q != '0;
		tag_s0.emit_pass = row_q == ROW_W'(GRID_HEIGHT - 1);
		tag_s0.border    = (row_q == ROW_W'(1)) || (col_q == '0) || col_wrap;
		tag_s0.frame_end = tag_s0.emit_pass && col_wrap;
	end

	// Stage 1 holds the cell while the line buffer answers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1 <= tag_s0;
			cur_s1 <= cell_temp;
		end
	end

	// Line buffer: prefetch the column to the right, write back the shifted column
	assign rd_mid   = rd_data[TEMP_W-1:0];
	assign rd_above = rd_data[RAM_W-1:TEMP_W];
	assign wr_data  = {nxt_mid_q, cur_s1};

	hds_ram #(
		.WIDTH(RAM_W),
		.DEPTH(GRID_WIDTH)
	) u_line_buf (
		.clk  (clk),
		.we   (vld_s1),
		.waddr(tag_s1.col),
		.wdata(wr_data),
		.re   (accept),
		.raddr(col_nx),
		.rdata(rd_data)
	);

	// Slide the window one column per cell
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			left_q      <= nxt_mid_q;
			nxt_mid_q   <= rd_mid;
			nxt_above_q <= rd_above;
		end
	end

	hds_calc u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef_x   (coef_x_q),
		.coef_y   (coef_y_q),
		.vld_s1   (vld_s1),
		.tag_s1   (tag_s1),
		.left     (left_q),
		.center   (nxt_mid_q),
		.right    (rd_mid),
		.above    (nxt_above_q),
		.below    (cur_s1),
		.stage_vld(stage_vld),
		.push     (push)
	);

	// Result queue and output port
	assign pop = res_valid && !res_stall;

	hds_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.count (oq_count)
	);

	assign res_valid   = oq_count != '0;
	assign out_row     = head.row;
	assign out_col     = head.col;
	assign out_temp    = head.temp;
	assign sat_flag    = head.sat;
	assign last_of_run = head.last;
	assign frame_done  = head.frame_done;

endmodule

FILE: hdl/hds_chk.sv
// Port-level checker for the heat diffusion stencil step unit, bound to the top level.
module hds_chk
	import hds_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     res_valid,
	input logic                     res_stall,
	input logic [IDX_W-1:0]         out_row,
	input logic [IDX_W-1:0]         out_col,
	input logic signed [TEMP_W-1:0] out_temp,
	input logic                     sat_flag,
	input logic                     last_of_run,
	input logic                     frame_done
);

	// Hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_temp) && $stable(out_row)
			&& $stable(out_col))
		else $error("stalled result changed");

	// Final grid cell closes its run and sits in the last corner
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_done |-> last_of_run
			&& out_row == IDX_W'(GRID_HEIGHT - 1) && out_col == IDX_W'(GRID_WIDTH - 1))
		else $error("frame_done on a wrong result");

	// Saturated values sit on a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && sat_flag |-> out_temp == TEMP_MAX || out_temp == TEMP_MIN)
		else $error("saturated result off the range limit");

	// A result that does not close its run is followed at once by the cell below it
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !last_of_run |=> res_valid && last_of_run
			&& !sat_flag && out_col == $past(out_col)
			&& out_row == IDX_W'($past(out_row) + 1'b1))
		else $error("pass-through result missing after its pair");

endmodule

bind heat_diffusion_stencil_step_unit hds_chk u_hds_chk (.*);
